// ----- rtl/core/scrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console ring buffer package
// Shared request codes, character constants and control structs for the
// console ring buffer engine.
// ----------------------------------------------------------------------------
package scrb_pkg;

	// Request kinds carried on the input channel.
	typedef enum logic [1:0] {
		KIND_HOST_WR    = 2'd0,
		KIND_HOST_RD    = 2'd1,
		KIND_LINE_RX    = 2'd2,
		KIND_LINE_READY = 2'd3
	} kind_t;

	// Source of the byte shown with a result.
	typedef enum logic [1:0] {
		SRC_NONE = 2'd0,
		SRC_RX   = 2'd1,
		SRC_TX   = 2'd2
	} src_t;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Operation applied to one ring for one request.
	typedef struct packed {
		logic push;      // write byte 0
		logic push_two;  // also write byte 1 after byte 0
		logic pop;       // read one byte
	} ring_cmd_t;

	// Occupancy status of one ring.
	typedef struct packed {
		logic empty;
		logic full;
		logic room2;     // at least two free slots
	} ring_stat_t;

endpackage

// ----- rtl/core/scrb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console ring buffer channels
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------

// Request channel: one console event per request.
interface scrb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel: one result per request.
interface scrb_out_if;
	logic       valid;
	logic       ready;
	logic       done_res;
	logic [7:0] out_byte;
	logic       tx_request_armed;

	modport source (output valid, output done_res, output out_byte,
		output tx_request_armed, input ready);
	modport sink   (input valid, input done_res, input out_byte,
		input tx_request_armed, output ready);
endinterface

// Configuration write channel for the echo enable register.
interface scrb_cfg_if;
	logic valid;
	logic ready;
	logic echo_enable;

	modport source (output valid, output echo_enable, input ready);
	modport sink   (input valid, input echo_enable, output ready);
endinterface

// ----- rtl/core/scrb_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console byte ring
// Byte ring holding up to DEPTH-1 bytes. Storage is split into an even and
// an odd bank so that two consecutive bytes can be written in the same cycle.
// ----------------------------------------------------------------------------
module scrb_ring
	import scrb_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ring_cmd_t  cmd,
	input  logic [7:0] wr_byte0,
	input  logic [7:0] wr_byte1,
	output ring_stat_t stat,
	output logic [7:0] rd_byte
);

	// Physical slots are rounded up to an even count so banks alternate.
	localparam int PHYS = DEPTH + (DEPTH % 2);
	localparam int PW   = (PHYS > 1) ? $clog2(PHYS) : 1;
	localparam int BANK = PHYS / 2;
	localparam int AW   = (BANK > 1) ? $clog2(BANK) : 1;
	localparam int CW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wp1, wp2, rp1;
	logic [PW-1:0] wp_half, wp1_half, rp_half;
	logic [AW-1:0] even_addr, odd_addr, rd_addr;
	logic [7:0]    even_data, odd_data;
	logic          even_we, odd_we;
	logic [7:0]    mem_even [BANK];
	logic [7:0]    mem_odd [BANK];
	logic [7:0]    rd_even_q, rd_odd_q;
	logic          rd_sel_q;
	logic [1:0]    push_cnt;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(PHYS - 1)) ? '0 : p + PW'(1);
	endfunction

	// Occupancy from the fill count.
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH - 1));
	assign stat.room2 = (count_q < CW'(DEPTH - 2));

	// Next pointer values and bank addresses.
	assign wp1      = ptr_inc(wp_q);
	assign wp2      = ptr_inc(wp1);
	assign rp1      = ptr_inc(rp_q);
	assign wp_half  = wp_q >> 1;
	assign wp1_half = wp1 >> 1;
	assign rp_half  = rp_q >> 1;
	assign rd_addr  = AW'(rp_half);
	assign push_cnt = {1'b0, cmd.push} + {1'b0, cmd.push_two};

	// Route each pushed byte to the bank its slot parity selects.
	always_comb begin
		if (wp_q[0]) begin
			odd_we    = cmd.push;
			odd_addr  = AW'(wp_half);
			odd_data  = wr_byte0;
			even_we   = cmd.push_two;
			even_addr = AW'(wp1_half);
			even_data = wr_byte1;
		end else begin
			even_we   = cmd.push;
			even_addr = AW'(wp_half);
			even_data = wr_byte0;
			odd_we    = cmd.push_two;
			odd_addr  = AW'(wp1_half);
			odd_data  = wr_byte1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (cmd.push_two) begin
				wp_q <= wp2;
			end else if (cmd.push) begin
				wp_q <= wp1;
			end
			if (cmd.pop) begin
				rp_q <= rp1;
			end
			count_q <= count_q + CW'(push_cnt) - CW'(cmd.pop);
		end
	end

	// Even bank storage with registered read.
	always_ff @(posedge clk) begin
		if (even_we) begin
			mem_even[even_addr] <= even_data;
		end
		if (cmd.pop && !rp_q[0]) begin
			rd_even_q <= mem_even[rd_addr];
		end
	end

	// Odd bank storage with registered read.
	always_ff @(posedge clk) begin
		if (odd_we) begin
			mem_odd[odd_addr] <= odd_data;
		end
		if (cmd.pop && rp_q[0]) begin
			rd_odd_q <= mem_odd[rd_addr];
		end
	end

	// Remember which bank served the last pop.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			rd_sel_q <= rp_q[0];
		end
	end

	assign rd_byte = rd_sel_q ? rd_odd_q : rd_even_q;

endmodule

// ----- rtl/core/scrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console request control
// Decodes each accepted request against ring status, issues the ring
// operations, tracks the transmit request and holds the result register.
// ----------------------------------------------------------------------------
module scrb_ctrl
	import scrb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       done_res,
	output src_t       src,
	output logic       tx_request_armed,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_echo,
	input  ring_stat_t tx_stat,
	input  ring_stat_t rx_stat,
	output ring_cmd_t  tx_cmd,
	output ring_cmd_t  rx_cmd
);

	logic accept;
	logic out_valid_q;
	logic done_q;
	src_t src_q;
	logic armed_q;
	logic echo_q;
	logic done_d;
	src_t src_d;
	logic armed_d;

	// A new request enters whenever the result register is free or draining.
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Request decode and ring operations.
	always_comb begin
		tx_cmd  = '0;
		rx_cmd  = '0;
		done_d  = 1'b0;
		src_d   = SRC_NONE;
		armed_d = armed_q;
		if (accept) begin
			unique case (kind_t'(kind))
				KIND_HOST_WR: begin
					tx_cmd.push = !tx_stat.full;
					done_d      = !tx_stat.full;
					if (!tx_stat.full || !tx_stat.empty) begin
						armed_d = 1'b1;
					end
				end
				KIND_HOST_RD: begin
					if (!rx_stat.empty) begin
						rx_cmd.pop = 1'b1;
						done_d     = 1'b1;
						src_d      = SRC_RX;
					end
				end
				KIND_LINE_RX: begin
					rx_cmd.push = !rx_stat.full;
					done_d      = !rx_stat.full;
					// Echo: a carriage return also gets a line feed if it fits.
					if (echo_q) begin
						if (!tx_stat.full) begin
							tx_cmd.push     = 1'b1;
							tx_cmd.push_two = (data_byte == CHAR_CR) && tx_stat.room2;
						end
						if (!tx_stat.full || !tx_stat.empty) begin
							armed_d = 1'b1;
						end
					end
				end
				KIND_LINE_READY: begin
					if (armed_q) begin
						if (!tx_stat.empty) begin
							tx_cmd.pop = 1'b1;
							done_d     = 1'b1;
							src_d      = SRC_TX;
						end else begin
							armed_d = 1'b0;
						end
					end
				end
				default: begin
					done_d = 1'b0;
				end
			endcase
		end
	end

	// Control state: result valid, transmit request and echo enable.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
			echo_q      <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			armed_q <= armed_d;
			if (cfg_valid) begin
				echo_q <= cfg_echo;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			done_q <= done_d;
			src_q  <= src_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign done_res         = done_q;
	assign src              = src_q;
	assign tx_request_armed = armed_q;

endmodule

// ----- rtl/core/serial_console_ring_buffers_echo_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console ring buffer engine
// Transmit and receive byte rings with host access, line events and
// optional echo of received bytes with CR expanded to CR LF.
// ----------------------------------------------------------------------------
// Latency: the result of a request is valid on the cycle after it is accepted.
// Throughput: one request per cycle while no result is stalled; each request does
// at most one operation per ring; popped bytes come from registered bank reads.
// Reset clears ring pointers, fill counts, the transmit request, echo enable
// and the result valid at once; ring storage is not cleared and needs no
// clearing pass, so requests are taken as soon as reset is released.
module serial_console_ring_buffers_echo_top
	import scrb_pkg::*;
#(
	parameter int TX_DEPTH = 64,
	parameter int RX_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	scrb_in_if.sink     in_req,
	scrb_out_if.source  out_res,
	scrb_cfg_if.sink    cfg
);

	ring_cmd_t  tx_cmd, rx_cmd;
	ring_stat_t tx_stat, rx_stat;
	logic [7:0] tx_rd_byte, rx_rd_byte;
	src_t       src;

	// Request decode, transmit request and result register.
	scrb_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_req.valid),
		.in_ready         (in_req.ready),
		.kind             (in_req.kind),
		.data_byte        (in_req.data_byte),
		.out_ready        (out_res.ready),
		.out_valid        (out_res.valid),
		.done_res         (out_res.done_res),
		.src              (src),
		.tx_request_armed (out_res.tx_request_armed),
		.cfg_valid        (cfg.valid),
		.cfg_ready        (cfg.ready),
		.cfg_echo         (cfg.echo_enable),
		.tx_stat          (tx_stat),
		.rx_stat          (rx_stat),
		.tx_cmd           (tx_cmd),
		.rx_cmd           (rx_cmd)
	);

	// Transmit ring: host writes and echoed bytes in, line sends out.
	scrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (tx_cmd),
		.wr_byte0 (in_req.data_byte),
		.wr_byte1 (CHAR_LF),
		.stat     (tx_stat),
		.rd_byte  (tx_rd_byte)
	);

	// Receive ring: line bytes in, host reads out.
	scrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (rx_cmd),
		.wr_byte0 (in_req.data_byte),
		.wr_byte1 (in_req.data_byte),
		.stat     (rx_stat),
		.rd_byte  (rx_rd_byte)
	);

	// Pick the byte that the result carries.
	always_comb begin
		unique case (src)
			SRC_RX:  out_res.out_byte = rx_rd_byte;
			SRC_TX:  out_res.out_byte = tx_rd_byte;
			default: out_res.out_byte = 8'h00;
		endcase
	end

endmodule

// ----- rtl/core/scrb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console ring buffer port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module scrb_checker
	import scrb_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic       done_res,
	input logic [7:0] out_byte,
	input logic       tx_request_armed
);

	logic in_acc;

	assign in_acc = in_valid && in_ready;

	// A stalled result holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(done_res)
			&& $stable(out_byte) && $stable(tx_request_armed))
		else $error("stalled result changed");

	// Every accepted request shows a result on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("accepted request produced no result");

	// After a host write the transmit ring is never empty, so the request is armed.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (kind == KIND_HOST_WR) |=> tx_request_armed)
		else $error("transmit request not armed after host write");

	// Pushes return no byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (kind == KIND_HOST_WR || kind == KIND_LINE_RX) |=> out_byte == 8'h00)
		else $error("push request returned a byte");

endmodule

bind serial_console_ring_buffers_echo_top scrb_checker u_scrb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_req.valid),
	.in_ready         (in_req.ready),
	.kind             (in_req.kind),
	.out_valid        (out_res.valid),
	.out_ready        (out_res.ready),
	.done_res         (out_res.done_res),
	.out_byte         (out_res.out_byte),
	.tx_request_armed (out_res.tx_request_armed)
);

// ----- tb/sv/tb_serial_console_ring_buffers_echo_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial console ring buffer engine testbench
// Drives host writes and reads, received line bytes and line-ready events
// into the engine under random flow control on both channels. A local
// model of the transmit and receive rings predicts every result, and each
// returned result is compared field by field in arrival order. The echo
// enable register is switched between phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_serial_console_ring_buffers_echo_top;
	import scrb_pkg::*;

	localparam int TX_DEPTH = 64;
	localparam int RX_DEPTH = 64;
	localparam int ACTIVE_TARGET = 1100;

	typedef struct packed {
		logic       done_res;
		logic [7:0] out_byte;
		logic       tx_request_armed;
	} console_result_t;

	logic clk;
	logic arst_n;

	scrb_in_if  req_ch();
	scrb_out_if res_ch();
	scrb_cfg_if cfg_ch();

	serial_console_ring_buffers_echo_top #(
		.TX_DEPTH(TX_DEPTH),
		.RX_DEPTH(RX_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(req_ch),
		.out_res(res_ch),
		.cfg(cfg_ch)
	);

	// Local copy of the console rings and control state.
	logic [7:0] tx_ring_mdl [TX_DEPTH];
	logic [7:0] rx_ring_mdl [RX_DEPTH];
	int unsigned tx_rd_mdl, tx_wr_mdl, rx_rd_mdl, rx_wr_mdl;
	logic tx_armed_mdl;
	logic echo_mdl;

	console_result_t expected_results [$];
	int unsigned fail_count;
	int unsigned active_count;
	bit sender_steady;
	int unsigned sink_hold;
	int unsigned sink_pick;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit tx_push_mdl(logic [7:0] b);
		if (((tx_wr_mdl + 1) % TX_DEPTH) == tx_rd_mdl) begin
			return 1'b0;
		end
		tx_ring_mdl[tx_wr_mdl] = b;
		tx_wr_mdl = (tx_wr_mdl + 1) % TX_DEPTH;
		return 1'b1;
	endfunction

	// Apply one accepted request to the local rings and return its result.
	function automatic console_result_t predict_console(kind_t k, logic [7:0] d);
		console_result_t r;
		r = '0;
		case (k)
			KIND_HOST_WR: begin
				r.done_res = tx_push_mdl(d);
				if (tx_wr_mdl != tx_rd_mdl) tx_armed_mdl = 1'b1;
			end
			KIND_HOST_RD: begin
				if (rx_wr_mdl != rx_rd_mdl) begin
					r.out_byte = rx_ring_mdl[rx_rd_mdl];
					rx_rd_mdl = (rx_rd_mdl + 1) % RX_DEPTH;
					r.done_res = 1'b1;
				end
			end
			KIND_LINE_RX: begin
				if (((rx_wr_mdl + 1) % RX_DEPTH) != rx_rd_mdl) begin
					rx_ring_mdl[rx_wr_mdl] = d;
					rx_wr_mdl = (rx_wr_mdl + 1) % RX_DEPTH;
					r.done_res = 1'b1;
				end
				// Echo: a CR is followed by LF only if the CR itself found room.
				if (echo_mdl) begin
					if (d == CHAR_CR) begin
						if (tx_push_mdl(CHAR_CR)) void'(tx_push_mdl(CHAR_LF));
					end else begin
						void'(tx_push_mdl(d));
					end
					if (tx_wr_mdl != tx_rd_mdl) tx_armed_mdl = 1'b1;
				end
			end
			default: begin
				if (tx_armed_mdl) begin
					if (tx_wr_mdl != tx_rd_mdl) begin
						r.out_byte = tx_ring_mdl[tx_rd_mdl];
						tx_rd_mdl = (tx_rd_mdl + 1) % TX_DEPTH;
						r.done_res = 1'b1;
					end else begin
						tx_armed_mdl = 1'b0;
					end
				end
			end
		endcase
		r.tx_request_armed = tx_armed_mdl;
		return r;
	endfunction

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_data();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25) return CHAR_CR;
		if (r < 30) return CHAR_LF;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	// Send one request and record what it should produce.
	task automatic send_request(kind_t k, logic [7:0] d);
		int unsigned gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.kind <= k;
		req_ch.data_byte <= d;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		active_count++;
		expected_results.push_back(predict_console(k, d));
	endtask

	// Stop sending and wait until every expected result has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_echo_enable(logic v);
		wait_drained();
		cfg_ch.echo_enable <= v;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		echo_mdl = v;
	endtask

	// A run of random requests with the given weights in percent;
	// whatever is left over goes to line-ready events.
	task automatic run_phase(int unsigned n, int unsigned w_wr, int unsigned w_rd,
		int unsigned w_rx);
		int unsigned r;
		kind_t k;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < w_wr) k = KIND_HOST_WR;
			else if (r < w_wr + w_rd) k = KIND_HOST_RD;
			else if (r < w_wr + w_rd + w_rx) k = KIND_LINE_RX;
			else k = KIND_LINE_READY;
			send_request(k, pick_data());
		end
	endtask

	// Each operation at least once, the byte extremes, and the empty-ring cases.
	task automatic test_basic_ops();
		sender_steady = 1'b1;
		send_request(KIND_LINE_READY, 8'hFF);
		send_request(KIND_HOST_RD, 8'hFF);
		send_request(KIND_HOST_WR, 8'h00);
		send_request(KIND_HOST_WR, 8'hFF);
		send_request(KIND_LINE_READY, 8'h00);
		sender_steady = 1'b0;
		send_request(KIND_LINE_READY, 8'hA5);
		send_request(KIND_LINE_READY, 8'h5A);
		send_request(KIND_LINE_READY, 8'h00);
		send_request(KIND_LINE_RX, 8'hFF);
		send_request(KIND_LINE_RX, 8'h00);
		send_request(KIND_HOST_RD, 8'h00);
		send_request(KIND_HOST_RD, 8'hFF);
		send_request(KIND_HOST_RD, 8'h00);
		write_echo_enable(1'b1);
		sender_steady = 1'b1;
		send_request(KIND_LINE_RX, CHAR_CR);
		send_request(KIND_LINE_RX, 8'h55);
		send_request(KIND_LINE_READY, 8'h00);
		send_request(KIND_LINE_READY, 8'h00);
		send_request(KIND_LINE_READY, 8'h00);
		sender_steady = 1'b0;
		send_request(KIND_LINE_READY, 8'h00);
		send_request(KIND_HOST_RD, 8'h00);
		send_request(KIND_HOST_RD, 8'h00);
		write_echo_enable(1'b0);
	endtask

	// Fill both rings past full, then drain them past empty, with echo
	// off and on, so that the full-ring and short-space echo cases occur.
	task automatic test_fill_drain();
		for (int e = 0; e < 2; e++) begin
			write_echo_enable(logic'(e));
			run_phase(150, 45, 5, 45);
			sender_steady = 1'b1;
			run_phase(40, 40, 5, 50);
			sender_steady = 1'b0;
			run_phase(160, 5, 45, 5);
		end
	endtask

	// Random mix of phases with varied weights, echo switched between them
	// and a pause before the third phase where the sender waits for all results.
	task automatic test_random_mix();
		int unsigned w_wr, w_rd, w_rx;
		int unsigned phase_no;
		phase_no = 0;
		while (active_count < ACTIVE_TARGET) begin
			if ($urandom_range(0, 2) == 0) write_echo_enable(logic'($urandom_range(0, 1)));
			if (phase_no == 2) wait_drained();
			sender_steady = ($urandom_range(0, 3) == 0);
			w_wr = $urandom_range(5, 45);
			w_rd = $urandom_range(5, 45);
			w_rx = $urandom_range(5, 90 - w_wr - (w_rd > 45 ? 45 : w_rd));
			run_phase($urandom_range(20, 120), w_wr, w_rd, w_rx);
			sender_steady = 1'b0;
			phase_no++;
		end
	endtask

	// Result sink flow control: runs of ready, short stalls, a few long ones.
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold--;
		end else begin
			sink_pick = $urandom_range(0, 99);
			if (sink_pick < 55) begin
				res_ch.ready <= 1'b1;
				sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
					: $urandom_range(0, 12);
			end else if (sink_pick < 95) begin
				res_ch.ready <= 1'b0;
				sink_hold = $urandom_range(0, 3);
			end else begin
				res_ch.ready <= 1'b0;
				sink_hold = $urandom_range(10, 40);
			end
		end
	end

	// Compare each returned result with the oldest expectation.
	always @(posedge clk) begin
		console_result_t exp_res;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				note_failure($sformatf("unexpected result done=%0b byte=%02h armed=%0b",
					res_ch.done_res, res_ch.out_byte, res_ch.tx_request_armed));
			end else begin
				exp_res = expected_results.pop_front();
				if (res_ch.done_res !== exp_res.done_res
					|| res_ch.out_byte !== exp_res.out_byte
					|| res_ch.tx_request_armed !== exp_res.tx_request_armed) begin
					note_failure($sformatf(
						"mismatch: expected done=%0b byte=%02h armed=%0b, got done=%0b byte=%02h armed=%0b",
						exp_res.done_res, exp_res.out_byte, exp_res.tx_request_armed,
						res_ch.done_res, res_ch.out_byte, res_ch.tx_request_armed));
				end
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_HOST_WR;
		req_ch.data_byte = 8'h00;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.echo_enable = 1'b0;
		sink_hold = 0;
		fail_count = 0;
		active_count = 0;
		sender_steady = 1'b0;
		tx_rd_mdl = 0;
		tx_wr_mdl = 0;
		rx_rd_mdl = 0;
		rx_wr_mdl = 0;
		tx_armed_mdl = 1'b0;
		echo_mdl = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_fill_drain();
		test_random_mix();

		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/scrb_pkg.sv
rtl/core/scrb_if.sv
rtl/core/scrb_ring.sv
rtl/core/scrb_ctrl.sv
rtl/core/serial_console_ring_buffers_echo_top.sv
rtl/core/scrb_checker.sv
tb/sv/tb_serial_console_ring_buffers_echo_top.sv
